// ----- design/plist_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plist_pkg
// Shared types, sizes and codes for the positional list engine.
// ---------------------------------------------------------------------------
package plist_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int TYPE_W   = 2;
    localparam int STAT_W   = 2;

    // slave tdata: value then position, 40 bits = 5 whole bytes
    localparam int S_DATA_W = VALUE_W + POS_W;
    localparam int M_DATA_W = VALUE_W;
    localparam int M_USER_W = 1 + STAT_W;

    localparam logic [TYPE_W-1:0] REQ_FRONT  = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_BACK   = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      empty;
        logic                      last;
        logic [STAT_W-1:0]         status;
    } item_t;

    // ring slot of the entry at offset off from front; off <= CAPACITY
    function automatic idx_t slot_of(input idx_t front, input cnt_t off);
        logic [CNT_W:0] sum;
        begin
            sum = {{(CNT_W + 1 - IDX_W){1'b0}}, front} + {1'b0, off};
            if (sum >= (CNT_W + 1)'(CAPACITY)) begin
                sum = sum - (CNT_W + 1)'(CAPACITY);
            end
            slot_of = sum[IDX_W-1:0];
        end
    endfunction

endpackage

// ----- design/positional_list_engine.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed values in a ring memory: insert front, append, delete.
// ---------------------------------------------------------------------------
// Usage:
//   A request enters on the s_ channel: s_tuser is the request type (insert
//   at front, append at back, delete at position), s_tdata carries the value
//   and the position. After every request the whole list goes out on the m_
//   channel front to back, one item per entry, m_tlast on the final item and
//   the request status on every item. An empty list gives one item with the
//   empty flag set and m_tdata zero.
//   Timing: inserts and front deletes are done in the accept cycle. A
//   delete deeper in the list then moves each following entry down one
//   slot, one entry per cycle through the separate read and write ports
//   of the entry memory. The list is then read out through the registered
//   memory read at one item per cycle while the output buffer has room
//   and m_tready does not stall it.
//   s_tready is high only while no request is in progress; the last items of
//   one run may still sit in the two-entry output buffer when the next
//   request is taken.
//   A stalled m_tready halts the readout without losing items. Reset empties
//   the list; the entry memory itself is not cleared.
// ---------------------------------------------------------------------------
module positional_list_engine (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [plist_pkg::S_DATA_W-1:0]    s_tdata,   // [31:0] value, [39:32] position
    input  logic [plist_pkg::TYPE_W-1:0]      s_tuser,   // [1:0] req_type
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [plist_pkg::M_DATA_W-1:0]    m_tdata,   // [31:0] entry_value
    output logic [plist_pkg::M_USER_W-1:0]    m_tuser,   // [0] list_empty, [2:1] status
    output logic                              m_tlast
);
    import plist_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SHIFT = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    cnt_t                count_reg, count_next;
    idx_t                front_reg, front_next;
    cnt_t                off_reg, off_next;
    logic [STAT_W-1:0]   status_reg, status_next;

    // entry memory
    logic [VALUE_W-1:0]  mem [CAPACITY];
    logic [VALUE_W-1:0]  mem_rdata_reg;
    logic                mem_we, mem_re;
    idx_t                mem_waddr, mem_raddr;
    logic [VALUE_W-1:0]  mem_wdata;

    // shift write stage
    logic                sh_wr_pend_reg, sh_wr_pend_next;
    cnt_t                sh_wr_off_reg, sh_wr_off_next;

    // readout read stage
    logic                rd_pend_reg, rd_pend_next;
    logic                rd_last_reg, rd_last_next;
    logic                rd_empty_reg, rd_empty_next;
    logic [STAT_W-1:0]   rd_status_reg, rd_status_next;

    // output register plus one holding entry
    item_t               out_reg, out_next, hold_reg, hold_next, land_item;
    logic                out_valid_reg, out_valid_next;
    logic                hold_valid_reg, hold_valid_next;

    logic                accept, pop, issue_ok;
    logic [1:0]          occ;
    logic [VALUE_W-1:0]  in_value;
    logic [POS_W-1:0]    in_pos;
    cnt_t                pos_cnt;

    assign in_value = s_tdata[VALUE_W-1:0];
    assign in_pos   = s_tdata[S_DATA_W-1:VALUE_W];
    assign pos_cnt  = in_pos[CNT_W-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;

    assign occ      = {1'b0, out_valid_reg} + {1'b0, hold_valid_reg} + {1'b0, rd_pend_reg}
                      - {1'b0, pop};
    assign issue_ok = (occ < 2'd2);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        front_next      = front_reg;
        off_next        = off_reg;
        status_next     = status_reg;
        mem_we          = 1'b0;
        mem_waddr       = slot_of(front_reg, sh_wr_off_reg);
        mem_wdata       = mem_rdata_reg;
        mem_re          = 1'b0;
        mem_raddr       = slot_of(front_reg, off_reg);
        sh_wr_pend_next = 1'b0;
        sh_wr_off_next  = sh_wr_off_reg;
        rd_pend_next    = 1'b0;
        rd_last_next    = rd_last_reg;
        rd_empty_next   = rd_empty_reg;
        rd_status_next  = rd_status_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    status_next = STAT_DONE;
                    off_next    = '0;
                    state_next  = ST_EMIT;
                    if (s_tuser == REQ_FRONT || s_tuser == REQ_BACK) begin
                        if (count_reg >= cnt_t'(CAPACITY)) begin
                            status_next = STAT_FULL;
                        end else begin
                            mem_we     = 1'b1;
                            mem_wdata  = in_value;
                            count_next = count_reg + cnt_t'(1);
                            if (s_tuser == REQ_FRONT) begin
                                front_next = slot_of(front_reg, cnt_t'(CAPACITY - 1));
                                mem_waddr  = front_next;
                            end else begin
                                mem_waddr  = slot_of(front_reg, count_reg);
                            end
                        end
                    end else if (s_tuser == REQ_DELETE) begin
                        if ({{(POS_W - CNT_W){1'b0}}, count_reg} <= in_pos) begin
                            status_next = STAT_RANGE;
                        end else if (pos_cnt == '0) begin
                            front_next = slot_of(front_reg, cnt_t'(1));
                            count_next = count_reg - cnt_t'(1);
                        end else begin
                            // move following entries down one slot
                            off_next   = pos_cnt + cnt_t'(1);
                            state_next = ST_SHIFT;
                        end
                    end
                end
            end
            ST_SHIFT: begin
                // write of the entry read in the previous cycle
                mem_we = sh_wr_pend_reg;
                if (off_reg < count_reg) begin
                    mem_re          = 1'b1;
                    sh_wr_pend_next = 1'b1;
                    sh_wr_off_next  = off_reg - cnt_t'(1);
                    off_next        = off_reg + cnt_t'(1);
                end else begin
                    count_next = count_reg - cnt_t'(1);
                    off_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (issue_ok) begin
                    rd_pend_next   = 1'b1;
                    rd_status_next = status_reg;
                    if (count_reg == '0) begin
                        rd_empty_next = 1'b1;
                        rd_last_next  = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        mem_re        = 1'b1;
                        rd_empty_next = 1'b0;
                        rd_last_next  = (off_reg == count_reg - cnt_t'(1));
                        off_next      = off_reg + cnt_t'(1);
                        if (rd_last_next) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // landing of read data into the output buffer
    always_comb begin
        land_item.value  = rd_empty_reg ? '0 : mem_rdata_reg;
        land_item.empty  = rd_empty_reg;
        land_item.last   = rd_last_reg;
        land_item.status = rd_status_reg;

        out_next        = out_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && !pop;
        hold_valid_next = hold_valid_reg;

        if (!out_valid_reg || pop) begin
            if (hold_valid_reg) begin
                out_next        = hold_reg;
                out_valid_next  = 1'b1;
                hold_next       = land_item;
                hold_valid_next = rd_pend_reg;
            end else if (rd_pend_reg) begin
                out_next       = land_item;
                out_valid_next = 1'b1;
            end
        end else if (rd_pend_reg) begin
            hold_next       = land_item;
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            front_reg      <= '0;
            sh_wr_pend_reg <= 1'b0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            front_reg      <= front_next;
            sh_wr_pend_reg <= sh_wr_pend_next;
            rd_pend_reg    <= rd_pend_next;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        off_reg       <= off_next;
        status_reg    <= status_next;
        sh_wr_off_reg <= sh_wr_off_next;
        rd_last_reg   <= rd_last_next;
        rd_empty_reg  <= rd_empty_next;
        rd_status_reg <= rd_status_next;
        out_reg       <= out_next;
        hold_reg      <= hold_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.value;
    assign m_tuser  = {out_reg.status, out_reg.empty};
    assign m_tlast  = out_reg.last;

    // output buffer never holds more than it has room for
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({out_valid_reg, hold_valid_reg, rd_pend_reg}) <= 2)
        else $error("output buffer overrun");

    assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> out_valid_reg)
        else $error("holding entry valid without output item");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cnt_t'(CAPACITY))
        else $error("entry count beyond capacity");

    // no shift write may be left over once the block is ready again
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !sh_wr_pend_reg)
        else $error("shift write pending while idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("stalled output item changed");

endmodule

// ----- tb/list_readout_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// list_readout_checker
// Tracks the list of the positional list engine and checks every readout item.
// ---------------------------------------------------------------------------
// Each request accepted on the s_ channel is applied to a local ring copy of
// the list. The full readout it should cause is queued up front to back.
// Each item taken on the m_ channel is compared, field by field, with the
// oldest queued item.
// ---------------------------------------------------------------------------
module list_readout_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [plist_pkg::S_DATA_W-1:0] s_tdata,   // [31:0] value, [39:32] position
    input  logic [plist_pkg::TYPE_W-1:0]   s_tuser,   // [1:0] req_type
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [plist_pkg::M_DATA_W-1:0] m_tdata,   // [31:0] entry_value
    input  logic [plist_pkg::M_USER_W-1:0] m_tuser,   // [0] list_empty, [2:1] status
    input  logic                          m_tlast,
    output int                            fail_count,
    output int                            pending,
    output int                            items_checked,
    output int                            full_drops,
    output int                            range_misses,
    output plist_pkg::cnt_t               list_len
);
    import plist_pkg::*;

    logic signed [VALUE_W-1:0] ring_mem [CAPACITY];
    idx_t                      head;
    item_t                     expected_readout [$];

    function automatic idx_t ring_slot(input int off);
        return idx_t'((int'(head) + off) % CAPACITY);
    endfunction

    task automatic apply_request(input logic [TYPE_W-1:0] kind,
                                 input logic signed [VALUE_W-1:0] val,
                                 input logic [POS_W-1:0] pos);
        logic [STAT_W-1:0] st;
        item_t             it;
        st = STAT_DONE;
        case (kind)
            REQ_FRONT, REQ_BACK: begin
                if (int'(list_len) >= CAPACITY) begin
                    st = STAT_FULL;
                end else if (kind == REQ_FRONT) begin
                    head = ring_slot(CAPACITY - 1);
                    ring_mem[head] = val;
                    list_len = list_len + cnt_t'(1);
                end else begin
                    ring_mem[ring_slot(int'(list_len))] = val;
                    list_len = list_len + cnt_t'(1);
                end
            end
            REQ_DELETE: begin
                if (int'(pos) >= int'(list_len)) begin
                    st = STAT_RANGE;
                end else if (pos == '0) begin
                    head = ring_slot(1);
                    list_len = list_len - cnt_t'(1);
                end else begin
                    for (int k = int'(pos); k + 1 < int'(list_len); k++) begin
                        ring_mem[ring_slot(k)] = ring_mem[ring_slot(k + 1)];
                    end
                    list_len = list_len - cnt_t'(1);
                end
            end
            default: ;  // unused type: list untouched, still read out
        endcase

        if (st == STAT_FULL) full_drops++;
        if (st == STAT_RANGE) range_misses++;

        it.status = st;
        if (list_len == '0) begin
            it.value = '0;
            it.empty = 1'b1;
            it.last  = 1'b1;
            expected_readout.push_back(it);
        end else begin
            it.empty = 1'b0;
            for (int k = 0; k < int'(list_len); k++) begin
                it.value = ring_mem[ring_slot(k)];
                it.last  = (k + 1 == int'(list_len));
                expected_readout.push_back(it);
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        item_t want;
        logic  bad;
        if (!aresetn) begin
            list_len      = '0;
            head          = '0;
            expected_readout.delete();
            fail_count    = 0;
            items_checked = 0;
            full_drops    = 0;
            range_misses  = 0;
        end else begin
            // readout side first: a new request's items cannot leave on its accept edge
            if (m_tvalid && m_tready) begin
                if (expected_readout.size() == 0) begin
                    $error("list item with no request waiting: entry_value %0d",
                           $signed(m_tdata));
                    fail_count++;
                end else begin
                    want = expected_readout.pop_front();
                    items_checked++;
                    bad = 1'b0;
                    if (m_tdata !== want.value) begin
                        $error("entry_value: expected %0d, got %0d",
                               want.value, $signed(m_tdata));
                        bad = 1'b1;
                    end
                    if (m_tuser[0] !== want.empty) begin
                        $error("list_empty: expected %0d, got %0d", want.empty, m_tuser[0]);
                        bad = 1'b1;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_of_run: expected %0d, got %0d", want.last, m_tlast);
                        bad = 1'b1;
                    end
                    if (m_tuser[2:1] !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser[2:1]);
                        bad = 1'b1;
                    end
                    if (bad) fail_count++;
                end
            end
            if (s_tvalid && s_tready) begin
                apply_request(s_tuser, s_tdata[VALUE_W-1:0], s_tdata[S_DATA_W-1:VALUE_W]);
            end
        end
        pending = expected_readout.size();
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the positional list engine.
// ---------------------------------------------------------------------------
// A short directed sequence hits empty-list deletes, the unused request
// type, extreme values and deletes at front, middle, back and past the end.
// Random requests then alternate between fill-heavy and drain-heavy
// stretches so the list runs full and empty repeatedly. Both sides stall at
// random, except for one long clean stretch; once the readout is held off
// long enough for the engine to back up its input.
// ---------------------------------------------------------------------------
module tb;
    import plist_pkg::*;

    localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
    localparam int                CYCLE_LIMIT = 1_000_000;
    localparam int                RANDOM_REQS = 360;
    localparam int                HOLD_CYCLES = 600;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // [31:0] value, [39:32] position
    logic [TYPE_W-1:0]   s_tuser  = '0;   // [1:0] req_type
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // [31:0] entry_value
    logic [M_USER_W-1:0] m_tuser;         // [0] list_empty, [2:1] status
    logic                m_tlast;

    int   fail_count, pending, items_checked, full_drops, range_misses;
    cnt_t list_len;

    logic s_acc     = 1'b0;
    logic gaps_on   = 1'b1;
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   cycles    = 0;
    int   req_count = 0;

    always #5 aclk = ~aclk;

    positional_list_engine DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    list_readout_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending       (pending),
        .items_checked (items_checked),
        .full_drops    (full_drops),
        .range_misses  (range_misses),
        .list_len      (list_len)
    );

    // handshake seen at the last rising edge, read back at the falling edge
    always @(posedge aclk) begin
        s_acc <= s_tvalid && s_tready;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // readout side: random stalls, plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= !(gaps_on && $urandom_range(99) < 30);
        end
    end

    task automatic send_req(input logic [TYPE_W-1:0] kind,
                            input logic signed [VALUE_W-1:0] val,
                            input logic [POS_W-1:0] pos);
        if (gaps_on && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {pos, val};
        do @(negedge aclk); while (!s_acc);
        req_count++;
    endtask

    initial begin
        logic [TYPE_W-1:0]         kind;
        logic signed [VALUE_W-1:0] val;
        logic [POS_W-1:0]          pos;
        int                        r;
        int                        fill_bias;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty-list corner cases
        send_req(REQ_DELETE, 32'sh0, 8'd0);
        send_req(REQ_UNUSED, 32'sh1234_5678, 8'd3);
        send_req(REQ_DELETE, -32'sh1, 8'd255);
        // build a short list with extreme values
        send_req(REQ_FRONT, 32'sh7FFF_FFFF, 8'd0);
        send_req(REQ_BACK, 32'sh8000_0000, 8'd255);
        send_req(REQ_FRONT, 32'sh0, 8'd0);
        send_req(REQ_BACK, -32'sh1, 8'd0);
        send_req(REQ_FRONT, 32'sh5555_5555, 8'hAA);
        send_req(REQ_BACK, 32'shAAAA_AAAA, 8'h55);
        send_req(REQ_UNUSED, -32'sh1, 8'd0);
        // deletes: exactly at the count, last, middle, front, far out
        send_req(REQ_DELETE, 32'sh0, 8'd6);
        send_req(REQ_DELETE, -32'sh1, 8'd5);
        send_req(REQ_DELETE, 32'sh7FFF_FFFF, 8'd2);
        send_req(REQ_DELETE, 32'sh0, 8'd0);
        send_req(REQ_DELETE, 32'sh0, 8'd200);
        send_req(REQ_DELETE, 32'sh0, 8'd0);
        send_req(REQ_DELETE, 32'sh0, 8'd1);
        send_req(REQ_DELETE, 32'sh0, 8'd0);
        send_req(REQ_DELETE, 32'sh0, 8'd0);

        // random part: alternate fill-heavy and drain-heavy stretches
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n == 20)  gaps_on  <= 1'b0;   // long clean stretch
            if (n == 130) gaps_on  <= 1'b1;
            if (n == 160) hold_req <= 1'b1;
            fill_bias = ((n / 70) % 2 == 0) ? 85 : 20;

            r = $urandom_range(99);
            if (r < 10) begin
                case ($urandom_range(3))
                    0:       val = 32'sh7FFF_FFFF;
                    1:       val = 32'sh8000_0000;
                    2:       val = 32'sh0;
                    default: val = -32'sh1;
                endcase
            end else begin
                val = $urandom;
            end

            r = $urandom_range(99);
            if (r < fill_bias) begin
                kind = $urandom_range(1) ? REQ_BACK : REQ_FRONT;
                pos  = $urandom_range(255);
            end else if (r < 97) begin
                kind = REQ_DELETE;
                r = $urandom_range(99);
                if (r < 75 && list_len != '0) begin
                    pos = $urandom_range(int'(list_len) - 1);
                end else if (r < 85) begin
                    pos = POS_W'(list_len);
                end else begin
                    pos = $urandom_range(255);
                end
            end else begin
                kind = REQ_UNUSED;
                pos  = $urandom_range(255);
            end
            send_req(kind, val, pos);
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (140) @(negedge aclk);

        $display("Run covered %0d requests with %0d list items checked;", req_count,
                 items_checked);
        $display("%0d inserts hit a full list, %0d deletes fell past the end.",
                 full_drops, range_misses);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
